// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the segment intersection block
// expects clk_i and rst_ni in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SEGX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("segx assertion failed");

// same check, also active while reset is asserted
`define SEGX_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("segx assertion failed");

`endif

// ===== hw/rtl/segx_pkg.sv =====
// shared widths, numeric types and beat payloads of the segment intersection block
// no dependencies
`default_nettype none

package segx_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int NSTG       = 6;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  typedef struct packed {
    coord_t p1_x;
    coord_t p1_y;
    coord_t p2_x;
    coord_t p2_y;
    coord_t q1_x;
    coord_t q1_y;
    coord_t q2_x;
    coord_t q2_y;
  } segx_in_t;

  typedef struct packed {
    logic intersects;
  } segx_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/segx_in_if.sv =====
// valid/ready channel carrying one segment pair per beat
// depends on segx_pkg
`default_nettype none

interface segx_in_if;
  logic                valid;
  logic                ready;
  segx_pkg::segx_in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/segx_out_if.sv =====
// valid/ready channel carrying one intersection result per beat
// depends on segx_pkg
`default_nettype none

interface segx_out_if;
  logic                valid;
  logic                ready;
  segx_pkg::segx_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/segment_intersection_test_core.sv =====
// Segment intersection test core.
// in_i carries one segment pair (p1, p2, q1, q2) per beat, res_o one result
// bit per beat, both valid/ready; a beat moves when valid and ready are high.
// cfg_we_i/cfg_wdata_i write count_touching (reset 1); write it only while
// no beat is in flight.
// Throughput is one pair per cycle while res_o takes results. The stages are:
// coordinate differences and bounding box, eight 17x17 and eight 17x16
// multipliers, cross and dot sums with orientation signs, min/max of the
// projected q interval, overlap bounds, final compare and output register.
// Each stage holds a valid bit; a stage loads whenever it is empty or the
// stage after it moves, so bubbles are squeezed out and a stalled receiver
// holds the result in the output register while earlier stages keep filling.
// in_i.ready drops only when all six stages are full and res_o is stalled.
// Reset clears all valid bits and sets count_touching to 1.
// depends on segx_pkg, segx_in_if, segx_out_if, assert_macros.svh
`default_nettype none

module segment_intersection_test_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_wdata_i,
  segx_in_if.sink     in_i,
  segx_out_if.source  res_o
);
  import segx_pkg::*;

  logic            touch_q;
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] stg_rdy;

  // stage 0: differences, coordinates, degenerate and box flags
  diff_t  dif_q [12];
  coord_t crd_q [8];
  logic   s0_degen_q, s0_inbox_q;

  // stage 1: products
  prod_t  crs_q [8];
  prod_t  dot_q [8];
  logic   s1_degen_q, s1_inbox_q;

  // stage 2: orientation signs and dot sums
  logic [3:0] oz_q, on_q;
  sum_t   da_q, db_q, dp1_q, dp2_q;
  logic   s2_degen_q, s2_inbox_q;

  // stage 3: interval ends, decision flags
  sum_t   mn_q, mx_q, s3_dp1_q, s3_dp2_q;
  logic   s3_degen_q, s3_on_q, s3_col_q, s3_out_q, s3_edge_q;

  // stage 4: overlap bounds
  sum_t   lo_q, hi_q;
  logic   s4_degen_q, s4_on_q, s4_col_q, s4_out_q, s4_edge_q;

  // stage 5: result
  logic   res_q, res_d;

  segx_in_t in_d;
  assign in_d = in_i.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touch_q <= 1'b1;
    end else if (cfg_we_i) begin
      touch_q <= cfg_wdata_i;
    end
  end

  // ready ripples back from the receiver
  always_comb begin
    stg_rdy[NSTG-1] = !v_q[NSTG-1] || res_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stg_rdy[k] = !v_q[k] || stg_rdy[k+1];
    end
  end

  assign in_i.ready = stg_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (stg_rdy[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (stg_rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 0
  logic s0_degen_d, s0_inbox_d;
  always_comb begin
    s0_degen_d = (in_d.p1_x == in_d.p2_x) && (in_d.p1_y == in_d.p2_y);
    s0_inbox_d = ((in_d.p1_x >= in_d.q1_x && in_d.p1_x <= in_d.q2_x) ||
                  (in_d.p1_x >= in_d.q2_x && in_d.p1_x <= in_d.q1_x)) &&
                 ((in_d.p1_y >= in_d.q1_y && in_d.p1_y <= in_d.q2_y) ||
                  (in_d.p1_y >= in_d.q2_y && in_d.p1_y <= in_d.q1_y));
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[0]) begin
      dif_q[0]   <= diff_t'(in_d.p2_x) - diff_t'(in_d.p1_x);
      dif_q[1]   <= diff_t'(in_d.p2_y) - diff_t'(in_d.p1_y);
      dif_q[2]   <= diff_t'(in_d.q2_x) - diff_t'(in_d.q1_x);
      dif_q[3]   <= diff_t'(in_d.q2_y) - diff_t'(in_d.q1_y);
      dif_q[4]   <= diff_t'(in_d.q1_x) - diff_t'(in_d.p1_x);
      dif_q[5]   <= diff_t'(in_d.q1_y) - diff_t'(in_d.p1_y);
      dif_q[6]   <= diff_t'(in_d.q2_x) - diff_t'(in_d.p1_x);
      dif_q[7]   <= diff_t'(in_d.q2_y) - diff_t'(in_d.p1_y);
      dif_q[8]   <= diff_t'(in_d.p1_x) - diff_t'(in_d.q1_x);
      dif_q[9]   <= diff_t'(in_d.p1_y) - diff_t'(in_d.q1_y);
      dif_q[10]  <= diff_t'(in_d.p2_x) - diff_t'(in_d.q1_x);
      dif_q[11]  <= diff_t'(in_d.p2_y) - diff_t'(in_d.q1_y);
      crd_q[0]   <= in_d.p1_x;
      crd_q[1]   <= in_d.p1_y;
      crd_q[2]   <= in_d.p2_x;
      crd_q[3]   <= in_d.p2_y;
      crd_q[4]   <= in_d.q1_x;
      crd_q[5]   <= in_d.q1_y;
      crd_q[6]   <= in_d.q2_x;
      crd_q[7]   <= in_d.q2_y;
      s0_degen_q <= s0_degen_d;
      s0_inbox_q <= s0_inbox_d;
    end
  end

  // stage 1: cross terms of o1..o4, then dot terms along p
  always_ff @(posedge clk_i) begin
    if (stg_rdy[1]) begin
      crs_q[0]   <= prod_t'(dif_q[0]) * prod_t'(dif_q[5]);
      crs_q[1]   <= prod_t'(dif_q[1]) * prod_t'(dif_q[4]);
      crs_q[2]   <= prod_t'(dif_q[0]) * prod_t'(dif_q[7]);
      crs_q[3]   <= prod_t'(dif_q[1]) * prod_t'(dif_q[6]);
      crs_q[4]   <= prod_t'(dif_q[2]) * prod_t'(dif_q[9]);
      crs_q[5]   <= prod_t'(dif_q[3]) * prod_t'(dif_q[8]);
      crs_q[6]   <= prod_t'(dif_q[2]) * prod_t'(dif_q[11]);
      crs_q[7]   <= prod_t'(dif_q[3]) * prod_t'(dif_q[10]);
      for (int k = 0; k < 8; k++) begin
        dot_q[k] <= prod_t'(dif_q[k % 2]) * prod_t'(crd_q[k]);
      end
      s1_degen_q <= s0_degen_q;
      s1_inbox_q <= s0_inbox_q;
    end
  end

  // stage 2
  sum_t       crs_sum [4];
  logic [3:0] oz_d, on_d;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      crs_sum[k] = sum_t'(crs_q[2*k]) - sum_t'(crs_q[2*k+1]);
      oz_d[k]    = (crs_sum[k] == '0);
      on_d[k]    = crs_sum[k][SUM_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[2]) begin
      oz_q       <= oz_d;
      on_q       <= on_d;
      dp1_q      <= sum_t'(dot_q[0]) + sum_t'(dot_q[1]);
      dp2_q      <= sum_t'(dot_q[2]) + sum_t'(dot_q[3]);
      da_q       <= sum_t'(dot_q[4]) + sum_t'(dot_q[5]);
      db_q       <= sum_t'(dot_q[6]) + sum_t'(dot_q[7]);
      s2_degen_q <= s1_degen_q;
      s2_inbox_q <= s1_inbox_q;
    end
  end

  // stage 3
  logic s3_out_d, s3_edge_d;
  always_comb begin
    // a segment fully on one side of the other's line
    s3_out_d  = (!oz_q[0] && !oz_q[1] && (on_q[0] == on_q[1])) ||
                (!oz_q[2] && !oz_q[3] && (on_q[2] == on_q[3]));
    s3_edge_d = oz_q[0] || oz_q[1] || oz_q[2] || oz_q[3];
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[3]) begin
      mn_q       <= (da_q < db_q) ? da_q : db_q;
      mx_q       <= (da_q > db_q) ? da_q : db_q;
      s3_dp1_q   <= dp1_q;
      s3_dp2_q   <= dp2_q;
      s3_degen_q <= s2_degen_q;
      s3_on_q    <= s2_inbox_q && oz_q[2];
      s3_col_q   <= oz_q[0] && oz_q[1];
      s3_out_q   <= s3_out_d;
      s3_edge_q  <= s3_edge_d;
    end
  end

  // stage 4
  always_ff @(posedge clk_i) begin
    if (stg_rdy[4]) begin
      lo_q       <= (s3_dp1_q > mn_q) ? s3_dp1_q : mn_q;
      hi_q       <= (s3_dp2_q < mx_q) ? s3_dp2_q : mx_q;
      s4_degen_q <= s3_degen_q;
      s4_on_q    <= s3_on_q;
      s4_col_q   <= s3_col_q;
      s4_out_q   <= s3_out_q;
      s4_edge_q  <= s3_edge_q;
    end
  end

  // stage 5: output register
  always_comb begin
    priority if (s4_degen_q) begin
      res_d = touch_q && s4_on_q;
    end else if (s4_col_q) begin
      res_d = (lo_q == hi_q) ? touch_q : (lo_q < hi_q);
    end else if (s4_out_q) begin
      res_d = 1'b0;
    end else if (s4_edge_q) begin
      res_d = touch_q;
    end else begin
      res_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[5]) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid           = v_q[NSTG-1];
  assign res_o.data.intersects = res_q;

  `include "assert_macros.svh"

  `SEGX_ASSERT(a_blocked_full, !in_i.ready |-> (&v_q))
  `SEGX_ASSERT(a_beat_advances, (v_q[0] && stg_rdy[1]) |=> v_q[1])
  `SEGX_ASSERT(a_mid_advances, (v_q[3] && stg_rdy[4]) |=> v_q[4])
  `SEGX_ASSERT(a_result_held, (v_q[NSTG-1] && !res_o.ready) |=> (v_q[NSTG-1] && $stable(res_q)))
  `SEGX_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (v_q == '0 || rst_ni))

endmodule

`default_nettype wire

// ===== tb/sv/segment_intersection_test_core_tb.sv =====
// testbench for segment_intersection_test_core: directed shapes and random segment pairs
// under both touching settings, with bursty input and a stalling result receiver
// depends on segx_pkg, segx_in_if, segx_out_if and the core rtl
module segment_intersection_test_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import segx_pkg::*;

  typedef struct {
    segx_in_t pair;
    bit       hit;
  } pending_hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  segx_in_if  in_if ();
  segx_out_if res_if ();

  segment_intersection_test_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .res_o       (res_if)
  );

  pending_hit_t pending_hits[$];
  bit           count_touching = 1'b1;
  int           mismatch_count = 0;
  int unsigned  burst_left = 0;
  logic [15:0]  ready_pattern = 16'hFFFF;
  int unsigned  pattern_age = 0;

  always #6 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    res_if.ready = 1'b0;
  end

  // receiver stall pattern, reshuffled each time its randomly drawn age runs out
  always @(posedge clk_i) begin
    if (pattern_age == 0) begin
      pattern_age = $urandom_range(300, 40);
      case ($urandom_range(3))
        0: ready_pattern = 16'hFFFF;
        1: ready_pattern = 16'($urandom);
        2: ready_pattern = 16'($urandom) | 16'($urandom);
        default: ready_pattern = 16'($urandom) & 16'($urandom);
      endcase
      if (ready_pattern == 16'h0000) ready_pattern = 16'h0001;
    end
    pattern_age--;
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    res_if.ready <= ready_pattern[0];
  end

  function automatic int turn_sign(longint ax, longint ay, longint bx, longint by,
                                   longint cx, longint cy);
    longint cr;
    cr = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    if (cr > 0) return 1;
    if (cr < 0) return -1;
    return 0;
  endfunction

  function automatic bit segments_meet(segx_in_t s, bit touch);
    longint ax, ay, bx, by, cx, cy, ex, ey;
    longint vx, vy, qa, qb, lo, hi;
    int     o1, o2, o3, o4;
    ax = longint'(s.p1_x);
    ay = longint'(s.p1_y);
    bx = longint'(s.p2_x);
    by = longint'(s.p2_y);
    cx = longint'(s.q1_x);
    cy = longint'(s.q1_y);
    ex = longint'(s.q2_x);
    ey = longint'(s.q2_y);
    // point p against closed segment q
    if (ax == bx && ay == by) begin
      return touch && turn_sign(cx, cy, ex, ey, ax, ay) == 0 &&
             ax >= (cx < ex ? cx : ex) && ax <= (cx > ex ? cx : ex) &&
             ay >= (cy < ey ? cy : ey) && ay <= (cy > ey ? cy : ey);
    end
    o1 = turn_sign(ax, ay, bx, by, cx, cy);
    o2 = turn_sign(ax, ay, bx, by, ex, ey);
    o3 = turn_sign(cx, cy, ex, ey, ax, ay);
    o4 = turn_sign(cx, cy, ex, ey, bx, by);
    // collinear: overlap of projections onto p
    if (o1 == 0 && o2 == 0) begin
      vx = bx - ax;
      vy = by - ay;
      qa = vx * cx + vy * cy;
      qb = vx * ex + vy * ey;
      lo = vx * ax + vy * ay;
      hi = vx * bx + vy * by;
      if ((qa < qb ? qa : qb) > lo) lo = (qa < qb ? qa : qb);
      if ((qa > qb ? qa : qb) < hi) hi = (qa > qb ? qa : qb);
      if (lo == hi) return touch;
      return lo < hi;
    end
    if (o1 * o2 > 0 || o3 * o4 > 0) return 1'b0;
    if (o1 * o2 == 0 || o3 * o4 == 0) return touch;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : check_results
    pending_hit_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_hits.size() == 0) begin
        report_mismatch($sformatf("result beat %0b with no pair pending",
                                  res_if.data.intersects));
      end else begin
        want = pending_hits.pop_front();
        if (res_if.data.intersects !== want.hit) begin
          report_mismatch($sformatf(
            "p (%0d,%0d)-(%0d,%0d) q (%0d,%0d)-(%0d,%0d): intersects %b, want %b",
            want.pair.p1_x, want.pair.p1_y, want.pair.p2_x, want.pair.p2_y,
            want.pair.q1_x, want.pair.q1_y, want.pair.q2_x, want.pair.q2_y,
            res_if.data.intersects, want.hit));
        end
      end
    end
  end

  // called at a rising edge, returns at the edge where the beat is taken
  task automatic send_pair(input segx_in_t pair);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      burst_left = $urandom_range(30, 1);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data <= pair;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_hits.push_back('{pair: pair, hit: segments_meet(pair, count_touching)});
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (NSTG + 2) @(posedge clk_i);
  endtask

  task automatic set_count_touching(input bit value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    count_touching = value;
  endtask

  function automatic segx_in_t mk_pair(int ax, int ay, int bx, int by,
                                       int cx, int cy, int ex, int ey);
    segx_in_t s;
    s.p1_x = coord_t'(ax);
    s.p1_y = coord_t'(ay);
    s.p2_x = coord_t'(bx);
    s.p2_y = coord_t'(by);
    s.q1_x = coord_t'(cx);
    s.q1_y = coord_t'(cy);
    s.q2_x = coord_t'(ex);
    s.q2_y = coord_t'(ey);
    return s;
  endfunction

  function automatic int small_coord(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic segx_in_t random_pair();
    segx_in_t s;
    int bx, by, dx, dy, dspan, k1, k2, k3, k4;
    s = segx_in_t'({$urandom, $urandom, $urandom, $urandom});
    dspan = ($urandom_range(1) == 0) ? 40 : 3500;
    bx = small_coord(1000);
    by = small_coord(1000);
    dx = small_coord(dspan);
    dy = small_coord(dspan);
    k1 = small_coord(8);
    k2 = small_coord(8);
    k3 = small_coord(8);
    k4 = small_coord(8);
    case ($urandom_range(9))
      0, 1: ;
      2, 3: s = mk_pair(small_coord(6), small_coord(6), small_coord(6), small_coord(6),
                        small_coord(6), small_coord(6), small_coord(6), small_coord(6));
      4, 5: s = mk_pair(bx + k1 * dx, by + k1 * dy, bx + k2 * dx, by + k2 * dy,
                        bx + k3 * dx, by + k3 * dy, bx + k4 * dx, by + k4 * dy);
      6: begin
        s = mk_pair(small_coord(20), small_coord(20), small_coord(20), small_coord(20),
                    small_coord(20), small_coord(20), small_coord(20), small_coord(20));
        if ($urandom_range(1) == 0) begin
          s.q1_x = s.p2_x;
          s.q1_y = s.p2_y;
        end else begin
          s.q2_x = s.p1_x;
          s.q2_y = s.p1_y;
        end
      end
      7: s = mk_pair(bx + k1 * dx, by + k1 * dy, bx + k1 * dx, by + k1 * dy,
                     bx + k2 * dx, by + k2 * dy, bx + k3 * dx, by + k3 * dy);
      8: begin
        s = mk_pair(small_coord(10), small_coord(10), small_coord(10), small_coord(10),
                    small_coord(10), small_coord(10), 0, 0);
        s.q2_x = s.q1_x;
        s.q2_y = s.q1_y;
      end
      default: s = mk_pair(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                           edge_coord(), edge_coord(), edge_coord(), edge_coord());
    endcase
    return s;
  endfunction

  task automatic test_directed_shapes();
    send_pair(mk_pair(0, 0, 4, 4, 0, 4, 4, 0));
    send_pair(mk_pair(0, 0, 4, 0, 0, 1, 4, 1));
    send_pair(mk_pair(0, 0, 4, 0, 2, 0, 6, 0));
    send_pair(mk_pair(0, 0, 2, 2, 2, 2, 5, 5));
    send_pair(mk_pair(0, 0, 1, 1, 3, 3, 5, 5));
    send_pair(mk_pair(1, 1, 2, 2, 5, 5, 0, 0));
    send_pair(mk_pair(0, 0, 4, 0, 2, 0, 2, 3));
    send_pair(mk_pair(0, 0, 3, 1, 3, 1, 5, -2));
    send_pair(mk_pair(0, 0, 4, 0, 1, 1, 3, 5));
    send_pair(mk_pair(0, 0, 2, 0, 4, -1, 4, 1));
    send_pair(mk_pair(2, 2, 2, 2, 0, 0, 4, 4));
    send_pair(mk_pair(6, 6, 6, 6, 0, 0, 4, 4));
    send_pair(mk_pair(1, 2, 1, 2, 0, 0, 4, 4));
    send_pair(mk_pair(3, -3, 3, -3, 3, -3, 3, -3));
    send_pair(mk_pair(3, -3, 3, -3, -3, 3, -3, 3));
    send_pair(mk_pair(0, 0, 4, 4, 2, 2, 2, 2));
    send_pair(mk_pair(0, 0, 4, 4, 1, 3, 1, 3));
    send_pair(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(mk_pair(32767, -32768, 32767, 32767, 32767, 0, 32767, 32767));
    send_pair(mk_pair(-32768, -32768, 0, 0, 0, 0, 32767, 32767));
    send_pair(mk_pair(-32768, -32768, 32767, 32767, -32768, -32767, 32767, 32767));
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk_pair(-32768, -32768, 32767, 32766, 0, 0, 32767, 32767));
    send_pair(mk_pair(-32768, 0, 32767, 1, -32768, 1, 32767, 0));
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_pair(random_pair());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_shapes();
    set_count_touching(1'b0);
    test_directed_shapes();
    set_count_touching(1'b1);
    test_directed_shapes();

    set_count_touching(1'b0);
    test_random_mix(600);
    set_count_touching(1'b1);
    test_random_mix(700);
    set_count_touching(1'b0);
    test_random_mix(600);

    drain_results();
    repeat (4 * NSTG) @(posedge clk_i);
    if (mismatch_count == 0 && pending_hits.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results pending", pending_hits.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/segx_pkg.sv
hw/rtl/segx_in_if.sv
hw/rtl/segx_out_if.sv
hw/rtl/segment_intersection_test_core.sv
tb/sv/segment_intersection_test_core_tb.sv
